// File: design/bfa_pkg.sv
// Shared types and constants of the bitmap frame allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps

package bfa_pkg;

  // Map geometry. WORD_BITS is a power of two, so a frame index splits into
  // word and bit fields.
  localparam int MAX_FRAMES  = 4096;
  localparam int FRAME_SHIFT = 12;
  localparam int WORD_BITS   = 32;

  localparam int ADDR_W    = 32;
  localparam int LIM_W     = 13;
  localparam int MAP_WORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int FIDX_W    = WORD_AW + BIT_W;

  // The word summary is searched in groups of GRP words.
  localparam int GRP_W  = 4;
  localparam int GRP    = 1 << GRP_W;
  localparam int NGRP   = (MAP_WORDS + GRP - 1) / GRP;
  localparam int NGRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int SUM_N  = NGRP * GRP;

  localparam logic [LIM_W-1:0] TOTAL_RESET = LIM_W'(4096);

  typedef enum logic [1:0] {
    FUNC_ALLOC    = 2'd0,
    FUNC_FREE     = 2'd1,
    FUNC_RESERVE  = 2'd2,
    FUNC_MARK_ALL = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_RANGE = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic scan;
    logic pick;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_room;
  } dp_stat_t;

endpackage

// File: design/bfa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the used-frame bitmap; depends on nothing.
`timescale 1ns / 1ps

module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bfa_ctrl.sv
// Controller state machine of the frame allocator: sequences accept, scan,
// pick and commit. Depends on bfa_pkg for the command and status structs.
`timescale 1ns / 1ps

module bfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bfa_pkg::dp_stat_t   stat_i,
  output bfa_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK,
    S_COMMIT
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SCAN;
          end
        end
        S_SCAN:   state_q <= S_PICK;
        S_PICK:   state_q <= S_COMMIT;
        S_COMMIT: begin
          // The result can only be written once the output register has room.
          if (stat_i.out_room) begin
            state_q <= S_IDLE;
          end
        end
        default:  state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.scan    = (state_q == S_SCAN);
  assign cmd_o.pick    = (state_q == S_PICK);
  assign cmd_o.commit  = (state_q == S_COMMIT) && stat_i.out_room;

endmodule

// File: design/bfa_datapath.sv
// Datapath of the frame allocator: request registers, frame limit, word
// summary search, bitmap RAM read-modify-write and the output register.
// Depends on bfa_pkg and bfa_ram.
`timescale 1ns / 1ps

module bfa_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bfa_pkg::ctrl_cmd_t                  cmd_i,
  output bfa_pkg::dp_stat_t                   stat_o,
  input  logic [1:0]                          func_i,
  input  logic [bfa_pkg::ADDR_W-1:0]          addr_i,
  input  logic                                cfg_we_i,
  input  logic [bfa_pkg::LIM_W-1:0]           cfg_wdata_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [bfa_pkg::ADDR_W-1:0]          out_addr_o,
  output logic [1:0]                          out_status_o
);

  // Request and configuration.
  bfa_pkg::func_e                   func_q;
  logic [bfa_pkg::ADDR_W-1:0]       addr_q;
  logic [bfa_pkg::LIM_W-1:0]        total_q;

  // Per-word state in flip-flops: full means no free bit, valid means the
  // RAM word has been written since reset or the last mark-all.
  logic [bfa_pkg::MAP_WORDS-1:0]    full_q;
  logic [bfa_pkg::MAP_WORDS-1:0]    valid_q;

  // Group search results.
  logic [bfa_pkg::NGRP-1:0]         grp_any_q;
  logic [bfa_pkg::GRP_W-1:0]        grp_first_q [bfa_pkg::NGRP];
  logic [bfa_pkg::NGRP-1:0]         grp_any_d;
  logic [bfa_pkg::GRP_W-1:0]        grp_first_d [bfa_pkg::NGRP];

  // Picked word.
  logic [bfa_pkg::WORD_AW-1:0]      word_q;
  logic [bfa_pkg::BIT_W-1:0]        bit_q;
  logic                             empty_q;
  logic                             range_q;
  logic                             vld_rd_q;

  // Output register.
  logic                             out_valid_q;
  logic [bfa_pkg::ADDR_W-1:0]       out_addr_q;
  bfa_pkg::status_e                 out_status_q;

  logic [bfa_pkg::LIM_W-1:0]        lim;
  logic [bfa_pkg::LIM_W:0]          lim_words;
  logic [bfa_pkg::SUM_N-1:0]        cand;
  logic [bfa_pkg::NGRP_W-1:0]       g_sel;
  logic                             g_found;
  logic [bfa_pkg::ADDR_W-1:0]       fidx;
  logic                             frange;
  logic [bfa_pkg::WORD_AW-1:0]      rd_word;
  logic [bfa_pkg::WORD_BITS-1:0]    rdata;
  logic [bfa_pkg::WORD_BITS-1:0]    cur;
  logic [bfa_pkg::BIT_W-1:0]        low_bit;
  logic [bfa_pkg::FIDX_W-1:0]       aidx;
  logic                             alloc_ok;
  logic [bfa_pkg::BIT_W-1:0]        bit_sel;
  logic [bfa_pkg::WORD_BITS-1:0]    mask;
  logic [bfa_pkg::WORD_BITS-1:0]    new_word;
  logic                             is_alloc;
  logic                             is_rmw;
  logic                             do_write;

  // Frame limit is the register saturated to the map size.
  assign lim = (int'(total_q) > bfa_pkg::MAX_FRAMES) ?
               bfa_pkg::LIM_W'(bfa_pkg::MAX_FRAMES) : total_q;
  assign lim_words = ({1'b0, lim} + (bfa_pkg::LIM_W + 1)'(bfa_pkg::WORD_BITS - 1))
                     >> bfa_pkg::BIT_W;

  // A word is a candidate when it has a free bit and starts below the limit.
  always_comb begin
    cand = '0;
    for (int w = 0; w < bfa_pkg::SUM_N; w++) begin
      if (w < bfa_pkg::MAP_WORDS) begin
        cand[w] = !full_q[w] && ((bfa_pkg::LIM_W + 1)'(w) < lim_words);
      end
    end
  end

  always_comb begin
    for (int g = 0; g < bfa_pkg::NGRP; g++) begin
      grp_any_d[g]   = |cand[g*bfa_pkg::GRP +: bfa_pkg::GRP];
      grp_first_d[g] = '0;
      for (int k = bfa_pkg::GRP - 1; k >= 0; k--) begin
        if (cand[g*bfa_pkg::GRP + k]) begin
          grp_first_d[g] = bfa_pkg::GRP_W'(k);
        end
      end
    end
  end

  always_comb begin
    g_sel   = '0;
    g_found = 1'b0;
    for (int g = bfa_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        g_sel   = bfa_pkg::NGRP_W'(g);
        g_found = 1'b1;
      end
    end
  end

  assign fidx    = addr_q >> bfa_pkg::FRAME_SHIFT;
  assign frange  = fidx >= bfa_pkg::ADDR_W'(lim);
  assign is_alloc = (func_q == bfa_pkg::FUNC_ALLOC);
  assign is_rmw   = (func_q == bfa_pkg::FUNC_FREE) || (func_q == bfa_pkg::FUNC_RESERVE);
  assign rd_word = is_alloc ?
                   bfa_pkg::WORD_AW'({g_sel, grp_first_q[g_sel]}) :
                   fidx[bfa_pkg::BIT_W +: bfa_pkg::WORD_AW];

  bfa_ram #(
    .WIDTH(bfa_pkg::WORD_BITS),
    .DEPTH(bfa_pkg::MAP_WORDS)
  ) u_map (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .waddr_i(word_q),
    .wdata_i(new_word),
    .re_i   (cmd_i.pick),
    .raddr_i(rd_word),
    .rdata_o(rdata)
  );

  // A word never written since the last fill reads as all used.
  assign cur = vld_rd_q ? rdata : '1;

  always_comb begin
    low_bit = '0;
    for (int b = bfa_pkg::WORD_BITS - 1; b >= 0; b--) begin
      if (!cur[b]) begin
        low_bit = bfa_pkg::BIT_W'(b);
      end
    end
  end

  assign aidx     = {word_q, low_bit};
  assign alloc_ok = !empty_q && (bfa_pkg::ADDR_W'(aidx) < bfa_pkg::ADDR_W'(lim));
  assign bit_sel  = is_alloc ? low_bit : bit_q;
  assign mask     = bfa_pkg::WORD_BITS'(1) << bit_sel;
  assign new_word = (func_q == bfa_pkg::FUNC_FREE) ? (cur & ~mask) : (cur | mask);
  assign do_write = cmd_i.commit && ((is_alloc && alloc_ok) || (is_rmw && !range_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q <= bfa_pkg::func_e'(func_i);
      addr_q <= addr_i;
    end
    if (cmd_i.scan) begin
      grp_any_q <= grp_any_d;
      for (int g = 0; g < bfa_pkg::NGRP; g++) begin
        grp_first_q[g] <= grp_first_d[g];
      end
    end
    if (cmd_i.pick) begin
      word_q   <= rd_word;
      bit_q    <= fidx[bfa_pkg::BIT_W-1:0];
      empty_q  <= !g_found;
      range_q  <= frange;
      vld_rd_q <= valid_q[rd_word];
    end
    if (cmd_i.commit) begin
      out_addr_q   <= (is_alloc && alloc_ok) ?
                      (bfa_pkg::ADDR_W'(aidx) << bfa_pkg::FRAME_SHIFT) : '0;
      out_status_q <= (is_alloc && !alloc_ok) ? bfa_pkg::STAT_EMPTY :
                      (is_rmw && range_q)     ? bfa_pkg::STAT_RANGE :
                                                bfa_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q     <= bfa_pkg::TOTAL_RESET;
      full_q      <= '1;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        total_q <= cfg_wdata_i;
      end
      if (cmd_i.commit && (func_q == bfa_pkg::FUNC_MARK_ALL)) begin
        full_q  <= '1;
        valid_q <= '0;
      end else if (do_write) begin
        full_q[word_q]  <= &new_word;
        valid_q[word_q] <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.out_room = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_addr_o      = out_addr_q;
  assign out_status_o    = out_status_q;

endmodule

// File: design/bitmap_frame_allocator.sv
// Top level of the first-fit bitmap frame allocator.
// Instantiates bfa_ctrl and bfa_datapath; uses bfa_pkg.
`timescale 1ns / 1ps

// Usage
// Each request is one transfer on the slave stream: tuser carries the
// function (allocate, free, reserve, mark all used) and tdata the frame byte
// address, which only free and reserve look at. Every request yields exactly
// one transfer on the master stream: tdata is the allocated frame's byte
// address (zero unless an allocate succeeded) and tuser the status
// (ok, out of frames, frame out of range).
// Timing: an accepted request passes through the scan, pick and commit
// states, and its result is registered as it leaves commit; the next request
// is accepted only once the block is back in idle, so one request is served
// at a time. The steps are the summary search (per-group encoders in scan,
// group pick and RAM word read in pick) and the bitmap RAM read-modify-write.
// The result sits in an output register, so a waiting receiver does not stop
// the next request from being accepted; only a second result waits in the
// commit step until the first has been taken.
// Reset marks every frame used at once (per-word valid bits), sets the frame
// count to 4096 and empties the output register; no clearing pass is needed.
// cfg_we_i writes the frame count; write it only while no request is open.

module bitmap_frame_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [31:0]                 s_axis_tdata_i,  // [31:0] frame_address
  input  logic [1:0]                  s_axis_tuser_i,  // [1:0] func
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [31:0]                 m_axis_tdata_o,  // [31:0] alloc_address
  output logic [1:0]                  m_axis_tuser_o,  // [1:0] status
  input  logic                        cfg_we_i,
  input  logic [12:0]                 cfg_wdata_i
);

  bfa_pkg::ctrl_cmd_t cmd;
  bfa_pkg::dp_stat_t  stat;

  bfa_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  bfa_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .func_i      (s_axis_tuser_i),
    .addr_i      (s_axis_tdata_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_addr_o  (m_axis_tdata_o),
    .out_status_o(m_axis_tuser_o)
  );

  // A commit always leaves a result in the output register.
  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> m_axis_tvalid_o)
    else $error("commit did not produce a result");

  // No new request is taken in the cycle after one was accepted.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

  // Failed requests never report an address.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o != bfa_pkg::STAT_OK)) |-> (m_axis_tdata_o == '0))
    else $error("failed request carries a nonzero address");

  // Status codes stay within the defined set.
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> ((m_axis_tuser_o == bfa_pkg::STAT_OK) ||
                         (m_axis_tuser_o == bfa_pkg::STAT_EMPTY) ||
                         (m_axis_tuser_o == bfa_pkg::STAT_RANGE)))
    else $error("undefined status code");

endmodule

// File: bench/bitmap_frame_allocator_checker.sv
// Scoreboard for the bitmap frame allocator: watches both streams and the
// frame-count write port, keeps its own copy of the used map and compares.
// Depends on bfa_pkg for the map geometry, function and status codes.
`timescale 1ns / 1ps

module bitmap_frame_allocator_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_tvalid_i,
  input  logic                       s_tready_i,
  input  logic [bfa_pkg::ADDR_W-1:0] s_tdata_i,   // [31:0] frame_address
  input  logic [1:0]                 s_tuser_i,   // [1:0] func
  input  logic                       m_tvalid_i,
  input  logic                       m_tready_i,
  input  logic [bfa_pkg::ADDR_W-1:0] m_tdata_i,   // [31:0] alloc_address
  input  logic [1:0]                 m_tuser_i,   // [1:0] status
  input  logic                       cfg_we_i,
  input  logic [bfa_pkg::LIM_W-1:0]  cfg_wdata_i,
  output int                         open_o,
  output int                         fails_o,
  output int                         checked_o
);

  typedef struct packed {
    logic [bfa_pkg::ADDR_W-1:0] addr;
    bfa_pkg::status_e           status;
  } alloc_result_t;

  logic [bfa_pkg::MAX_FRAMES-1:0] frame_used;
  logic [bfa_pkg::LIM_W-1:0]      total_q;
  alloc_result_t                  pending_results[$];
  int                             fails   = 0;
  int                             checked = 0;

  // Serve one request against the shadow map and return what the block must answer.
  function automatic alloc_result_t apply_request(input bfa_pkg::func_e func,
                                                  input logic [bfa_pkg::ADDR_W-1:0] addr);
    alloc_result_t                                   res;
    int                                              limit;
    int                                              idx;
    logic [bfa_pkg::ADDR_W-bfa_pkg::FRAME_SHIFT-1:0] fidx;
    res.addr   = '0;
    res.status = bfa_pkg::STAT_OK;
    limit = (total_q > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : int'(total_q);
    case (func)
      bfa_pkg::FUNC_ALLOC: begin
        idx = -1;
        for (int i = 0; i < limit && idx < 0; i++) begin
          if (!frame_used[i]) idx = i;
        end
        if (idx < 0) begin
          res.status = bfa_pkg::STAT_EMPTY;
        end else begin
          frame_used[idx] = 1'b1;
          res.addr = bfa_pkg::ADDR_W'(idx) << bfa_pkg::FRAME_SHIFT;
        end
      end
      bfa_pkg::FUNC_FREE, bfa_pkg::FUNC_RESERVE: begin
        fidx = addr[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT];
        if (fidx >= limit) res.status = bfa_pkg::STAT_RANGE;
        else frame_used[fidx] = (func == bfa_pkg::FUNC_RESERVE);
      end
      default: frame_used = '1;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    alloc_result_t want;
    if (!rst_ni) begin
      frame_used = '1;
      total_q    = bfa_pkg::TOTAL_RESET;
      pending_results.delete();
      open_o    <= 0;
      fails_o   <= fails;
      checked_o <= checked;
    end else begin
      if (cfg_we_i) total_q = cfg_wdata_i;
      // A result always comes after the transfer of its request, so the output side
      // is handled before the request taken at the same edge is queued.
      if (m_tvalid_i && m_tready_i) begin
        if (pending_results.size() == 0) begin
          fails++;
          $display("%0t: result transfer with no request waiting: expected none, actual %h/%0d",
                   $time, m_tdata_i, m_tuser_i);
        end else begin
          want = pending_results.pop_front();
          checked++;
          if (m_tdata_i !== want.addr) begin
            fails++;
            $display("%0t: alloc_address mismatch: expected %h, actual %h",
                     $time, want.addr, m_tdata_i);
          end
          if (m_tuser_i !== want.status) begin
            fails++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, want.status, m_tuser_i);
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        pending_results.push_back(apply_request(bfa_pkg::func_e'(s_tuser_i), s_tdata_i));
      end
      open_o    <= pending_results.size();
      fails_o   <= fails;
      checked_o <= checked;
    end
  end

endmodule

// File: bench/bitmap_frame_allocator_tb.sv
// Top of the bitmap frame allocator bench: clock, reset, request stimulus,
// receiver stalls, watchdog and verdict. Uses bfa_pkg and the scoreboard module.
`timescale 1ns / 1ps

module bitmap_frame_allocator_tb;

  localparam int IDLE_LIMIT = 2000;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       s_tvalid;
  logic                       s_tready;
  logic [bfa_pkg::ADDR_W-1:0] s_tdata;
  logic [1:0]                 s_tuser;
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [bfa_pkg::ADDR_W-1:0] m_tdata;
  logic [1:0]                 m_tuser;
  logic                       cfg_we;
  logic [bfa_pkg::LIM_W-1:0]  cfg_wdata;

  int open;
  int fails;
  int checked;

  int n_sent      = 0;
  int n_settings  = 0;
  int cur_limit   = bfa_pkg::MAX_FRAMES;
  int burst_left  = 0;
  int rx_left     = 0;
  logic rx_ready  = 1'b0;
  int idle_cycles = 0;
  int phase_total[9] = '{4096, 1, 33, 0, 8191, 64, -1, 4096, 200};

  always #5 clk = ~clk;

  bitmap_frame_allocator u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  bitmap_frame_allocator_checker u_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .open_o      (open),
    .fails_o     (fails),
    .checked_o   (checked)
  );

  // Receiver: alternating ready and stall windows of random length, with an
  // occasional long ready stretch.
  always @(posedge clk) begin
    if (rx_left > 0) begin
      rx_left--;
    end else begin
      rx_ready = !rx_ready;
      if (rx_ready) begin
        rx_left = ($urandom_range(4) == 0) ? $urandom_range(80, 40) : $urandom_range(10, 1);
      end else begin
        rx_left = $urandom_range(12, 1);
      end
    end
    m_tready <= rx_ready;
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: timeout, no transfer for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  // Byte address of a frame with random offset bits inside the frame.
  function automatic logic [bfa_pkg::ADDR_W-1:0] addr_of(input int idx);
    return (bfa_pkg::ADDR_W'(idx) << bfa_pkg::FRAME_SHIFT) |
           bfa_pkg::ADDR_W'($urandom_range((1 << bfa_pkg::FRAME_SHIFT) - 1));
  endfunction

  // One request transfer; the sender runs in bursts and only drops tvalid
  // when a gap follows.
  task automatic issue(input bfa_pkg::func_e func, input logic [bfa_pkg::ADDR_W-1:0] addr);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata  <= addr;
    s_tuser  <= func;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(5) == 0) ? $urandom_range(60, 20) : $urandom_range(12);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(10, 1);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Frame-count write, made only once every result has drained.
  task automatic set_total(input logic [bfa_pkg::LIM_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (open != 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_limit = (value > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : int'(value);
    n_settings++;
  endtask

  initial begin
    int r;
    int idx;
    int sel;
    int value;
    int len;
    bfa_pkg::func_e func;
    logic [bfa_pkg::ADDR_W-1:0] addr;

    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = bfa_pkg::FUNC_ALLOC;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every frame is used after reset, so the first allocate fails.
    issue(bfa_pkg::FUNC_ALLOC, 32'hFFFF_FFFF);
    issue(bfa_pkg::FUNC_FREE, 32'h0000_0000);
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);     // frame zero: address zero, status ok
    issue(bfa_pkg::FUNC_FREE, 32'hFFFF_FFFF);      // index far out of range
    issue(bfa_pkg::FUNC_RESERVE, 32'h0100_0000);   // first index past the limit
    issue(bfa_pkg::FUNC_FREE, 32'h00FF_FFFF);      // top frame, offset bits all set
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);
    issue(bfa_pkg::FUNC_FREE, 32'h0000_5ABC);
    issue(bfa_pkg::FUNC_RESERVE, 32'h0000_5000);
    issue(bfa_pkg::FUNC_FREE, 32'h0001_F000);      // last bit of word zero
    issue(bfa_pkg::FUNC_FREE, 32'h0002_0FFF);      // first bit of word one
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);
    issue(bfa_pkg::FUNC_FREE, 32'h0000_7000);
    issue(bfa_pkg::FUNC_MARK_ALL, 32'hA5A5_A5A5);
    issue(bfa_pkg::FUNC_ALLOC, 32'h5A5A_5A5A);

    // A limit that ends inside a word.
    set_total(bfa_pkg::LIM_W'(37));
    issue(bfa_pkg::FUNC_FREE, addr_of(36));
    issue(bfa_pkg::FUNC_FREE, addr_of(37));
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);

    set_total(bfa_pkg::LIM_W'(0));
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);
    issue(bfa_pkg::FUNC_RESERVE, 32'h0000_0000);

    // Above the maximum the count saturates.
    set_total(bfa_pkg::LIM_W'(8191));
    issue(bfa_pkg::FUNC_FREE, addr_of(bfa_pkg::MAX_FRAMES - 1));
    issue(bfa_pkg::FUNC_FREE, addr_of(bfa_pkg::MAX_FRAMES));
    issue(bfa_pkg::FUNC_ALLOC, 32'h0000_0000);

    for (int p = 0; p < 9; p++) begin
      value = (phase_total[p] < 0) ? $urandom_range(8191) : phase_total[p];
      set_total(bfa_pkg::LIM_W'(value));
      len = (cur_limit == 0) ? 40 : 190;
      for (int k = 0; k < len; k++) begin
        r   = $urandom_range(99);
        idx = (cur_limit > 0) ? $urandom_range(cur_limit - 1) : 0;
        if (r < 42) begin
          issue(bfa_pkg::FUNC_ALLOC, $urandom);
        end else if (r < 97) begin
          func = (r < 80) ? bfa_pkg::FUNC_FREE : bfa_pkg::FUNC_RESERVE;
          sel  = $urandom_range(9);
          if (sel == 0) addr = $urandom;
          else if (sel == 1) addr = addr_of(cur_limit);
          else if (sel == 2) addr = addr_of(cur_limit - 1);
          else addr = addr_of(idx);
          issue(func, addr);
        end else begin
          issue(bfa_pkg::FUNC_MARK_ALL, $urandom);
        end
      end
    end

    s_tvalid <= 1'b0;
    do @(posedge clk); while (open != 0);
    repeat (10) @(posedge clk);

    $display("Covered %0d requests of all four kinds under %0d frame-count settings,",
             n_sent, n_settings);
    $display("including zero, limits inside a word and a saturating count; %0d results checked.",
             checked);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/bfa_pkg.sv
design/bfa_ram.sv
design/bfa_ctrl.sv
design/bfa_datapath.sv
design/bitmap_frame_allocator.sv
bench/bitmap_frame_allocator_checker.sv
bench/bitmap_frame_allocator_tb.sv
